// ===== rtl/slt_pkg.sv =====
// Shared types, codes, character constants and keyword table of the token descriptor lexer.
package slt_pkg;

    localparam int LINE_MAX_DEF    = 1024;
    localparam int KEYWORD_MAX_DEF = 7;
    localparam int KW_COUNT        = 15;
    localparam int KW_LONGEST      = 7;
    localparam int OUTQ_DEPTH      = 4;

    localparam logic [31:0] START_MAX = 32'd1023;
    localparam logic [31:0] LEN_MAX   = 32'd2047;

    // Characters the lexer recognizes
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_USCORE  = 8'h5F;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef enum logic [3:0] {
        M_IDLE,
        M_IDENT,
        M_INT,
        M_STR,
        M_CHVAL,
        M_CHSKIP,
        M_LT,
        M_GT,
        M_EQ,
        M_BANG
    } t_mode;

    typedef enum logic [5:0] {
        C_IDENFR     = 6'd0,
        C_INTCON     = 6'd1,
        C_CHARCON    = 6'd2,
        C_STRCON     = 6'd3,
        C_PLUS       = 6'd4,
        C_MINU       = 6'd5,
        C_MULT       = 6'd6,
        C_DIV        = 6'd7,
        C_LSS        = 6'd8,
        C_LEQ        = 6'd9,
        C_GRE        = 6'd10,
        C_GEQ        = 6'd11,
        C_EQL        = 6'd12,
        C_NEQ        = 6'd13,
        C_ASSIGN     = 6'd14,
        C_SEMICN     = 6'd15,
        C_COMMA      = 6'd16,
        C_LPARENT    = 6'd17,
        C_RPARENT    = 6'd18,
        C_LBRACK     = 6'd19,
        C_RBRACK     = 6'd20,
        C_LBRACE     = 6'd21,
        C_RBRACE     = 6'd22,
        C_COLON      = 6'd23,
        C_KW_CONST   = 6'd24,
        C_KW_INT     = 6'd25,
        C_KW_CHAR    = 6'd26,
        C_KW_VOID    = 6'd27,
        C_KW_MAIN    = 6'd28,
        C_KW_IF      = 6'd29,
        C_KW_ELSE    = 6'd30,
        C_KW_SWITCH  = 6'd31,
        C_KW_CASE    = 6'd32,
        C_KW_DEFAULT = 6'd33,
        C_KW_WHILE   = 6'd34,
        C_KW_FOR     = 6'd35,
        C_KW_SCANF   = 6'd36,
        C_KW_PRINTF  = 6'd37,
        C_KW_RETURN  = 6'd38
    } t_class;

    typedef struct packed {
        logic        last;
        logic [10:0] len;
        logic [9:0]  start;
        t_class      cls;
    } t_tok;

    typedef struct packed {
        logic [1:0] cnt;
        t_tok       tok1;
        t_tok       tok0;
    } t_res;

    // Keyword letters, first letter in the lowest byte (so each literal reads reversed)
    localparam logic [55:0] KW_TEXT [KW_COUNT] = '{
        56'("tsnoc"),   56'("tni"),     56'("rahc"),   56'("diov"),
        56'("niam"),    56'("fi"),      56'("esle"),   56'("hctiws"),
        56'("esac"),    56'("tluafed"), 56'("elihw"),  56'("rof"),
        56'("fnacs"),   56'("ftnirp"),  56'("nruter")
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd5, 3'd3, 3'd4, 3'd4, 3'd4, 3'd2, 3'd4, 3'd6,
        3'd4, 3'd7, 3'd5, 3'd3, 3'd5, 3'd6, 3'd6
    };

    // Match lowercase letters against all keywords in parallel
    function automatic t_class kw_class(input logic [55:0] letters, input logic [2:0] len);
        t_class res;
        logic   hit;
        res = C_IDENFR;
        for (int k = 0; k < KW_COUNT; k++) begin
            hit = (len == KW_LEN[k]);
            for (int i = 0; i < KW_LONGEST; i++) begin
                if (i < int'(KW_LEN[k]) && letters[8*i +: 8] != KW_TEXT[k][8*i +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                res = t_class'(6'(C_KW_CONST) + 6'(k));
            end
        end
        return res;
    endfunction

    function automatic logic [9:0] clamp_start(input logic [31:0] v);
        return (v > START_MAX) ? START_MAX[9:0] : v[9:0];
    endfunction

    function automatic logic [10:0] clamp_len(input logic [31:0] v);
        return (v > LEN_MAX) ? LEN_MAX[10:0] : v[10:0];
    endfunction

endpackage

// ===== rtl/slt_lexer.sv =====
// Lexer state registers and the single-pass next-state and descriptor logic.
module slt_lexer #(
    parameter int LINE_MAX    = slt_pkg::LINE_MAX_DEF,
    parameter int KEYWORD_MAX = slt_pkg::KEYWORD_MAX_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [7:0]    i_char_code,
    input  logic          i_line_end,
    output slt_pkg::t_res o_res
);

    localparam int CW = $clog2(LINE_MAX);
    localparam int RW = $clog2(LINE_MAX + 1);
    localparam int KW = $clog2(KEYWORD_MAX);
    localparam logic [CW-1:0] COL_MAX = CW'(LINE_MAX - 1);
    localparam logic [RW-1:0] RUN_MAX = RW'(LINE_MAX);
    localparam logic [RW-1:0] KW_MAX  = RW'(KEYWORD_MAX);
    localparam logic [RW-1:0] KW_LIM  = RW'(slt_pkg::KW_LONGEST);

    slt_pkg::t_mode r_mode, n_mode;
    logic [CW-1:0]  r_col, n_col;
    logic [CW-1:0]  r_start, n_start;
    logic [RW-1:0]  r_run, n_run;
    logic           r_kwp, n_kwp;
    logic [7:0]     r_let [KEYWORD_MAX];
    logic [7:0]     n_let [KEYWORD_MAX];

    logic [7:0]      c;
    logic            c_letter, c_digit, c_word;
    logic [7:0]      c_lower;
    logic [RW-1:0]   run_sat;
    logic [CW-1:0]   col_sat;
    logic [55:0]     kw_vec;
    slt_pkg::t_class id_cls;

    logic            e0_v, e1_v, use_fresh;
    slt_pkg::t_class e0_cls, e1_cls;
    logic [31:0]     e0_s, e0_l, e1_s, e1_l;
    slt_pkg::t_tok   t0, t1;

    assign c        = i_char_code;
    assign c_letter = (c >= slt_pkg::CH_LOW_A && c <= slt_pkg::CH_LOW_Z) ||
                      (c >= slt_pkg::CH_UP_A && c <= slt_pkg::CH_UP_Z);
    assign c_digit  = (c >= slt_pkg::CH_DIGIT_0 && c <= slt_pkg::CH_DIGIT_9);
    assign c_word   = c_letter || c_digit || (c == slt_pkg::CH_USCORE);
    assign c_lower  = (c >= slt_pkg::CH_UP_A && c <= slt_pkg::CH_UP_Z) ?
                      c + slt_pkg::CASE_OFFSET : c;
    assign run_sat  = (r_run < RUN_MAX) ? r_run + RW'(1) : r_run;
    assign col_sat  = (r_col < COL_MAX) ? r_col + CW'(1) : r_col;

    always_comb begin
        for (int i = 0; i < slt_pkg::KW_LONGEST; i++) begin
            kw_vec[8*i +: 8] = r_let[i];
        end
    end

    assign id_cls = (r_kwp && r_run <= KW_LIM) ? slt_pkg::kw_class(kw_vec, r_run[2:0])
                                               : slt_pkg::C_IDENFR;

    always_comb begin
        n_mode    = r_mode;
        n_col     = r_col;
        n_start   = r_start;
        n_run     = r_run;
        n_kwp     = r_kwp;
        n_let     = r_let;
        e0_v      = 1'b0;
        e0_cls    = slt_pkg::C_IDENFR;
        e0_s      = 32'(r_start);
        e0_l      = 32'(r_run);
        e1_v      = 1'b0;
        e1_cls    = slt_pkg::C_IDENFR;
        e1_s      = 32'(r_col);
        e1_l      = 32'd1;
        use_fresh = 1'b0;

        if (i_line_end) begin
            // close whatever is open at the end of the line
            unique case (r_mode)
                slt_pkg::M_IDENT: begin
                    e0_v   = 1'b1;
                    e0_cls = id_cls;
                end
                slt_pkg::M_INT: begin
                    e0_v   = 1'b1;
                    e0_cls = slt_pkg::C_INTCON;
                end
                slt_pkg::M_STR: begin
                    e0_v   = 1'b1;
                    e0_cls = slt_pkg::C_STRCON;
                end
                slt_pkg::M_CHVAL: begin
                    e0_v   = 1'b1;
                    e0_cls = slt_pkg::C_CHARCON;
                    e0_s   = 32'(r_col);
                    e0_l   = 32'd0;
                end
                slt_pkg::M_LT: begin
                    e0_v   = 1'b1;
                    e0_cls = slt_pkg::C_LSS;
                    e0_l   = 32'd1;
                end
                slt_pkg::M_GT: begin
                    e0_v   = 1'b1;
                    e0_cls = slt_pkg::C_GRE;
                    e0_l   = 32'd1;
                end
                slt_pkg::M_EQ: begin
                    e0_v   = 1'b1;
                    e0_cls = slt_pkg::C_ASSIGN;
                    e0_l   = 32'd1;
                end
                slt_pkg::M_BANG: begin
                    e0_v   = 1'b1;
                    e0_cls = slt_pkg::C_NEQ;
                    e0_l   = 32'd1;
                end
                default: ;
            endcase
            n_mode = slt_pkg::M_IDLE;
            n_col  = '0;
            n_run  = '0;
        end else begin
            unique case (r_mode)
                slt_pkg::M_IDENT: begin
                    if (c_word) begin
                        if (c_letter && r_run < KW_MAX) begin
                            n_let[r_run[KW-1:0]] = c_lower;
                        end else begin
                            n_kwp = 1'b0;
                        end
                        n_run = run_sat;
                    end else begin
                        e0_v      = 1'b1;
                        e0_cls    = id_cls;
                        n_mode    = slt_pkg::M_IDLE;
                        use_fresh = 1'b1;
                    end
                end
                slt_pkg::M_INT: begin
                    if (c_digit) begin
                        n_run = run_sat;
                    end else begin
                        e0_v      = 1'b1;
                        e0_cls    = slt_pkg::C_INTCON;
                        n_mode    = slt_pkg::M_IDLE;
                        use_fresh = 1'b1;
                    end
                end
                slt_pkg::M_STR: begin
                    if (c == slt_pkg::CH_DQUOTE) begin
                        e0_v   = 1'b1;
                        e0_cls = slt_pkg::C_STRCON;
                        n_mode = slt_pkg::M_IDLE;
                    end else begin
                        n_run = run_sat;
                    end
                end
                slt_pkg::M_CHVAL: begin
                    e0_v   = 1'b1;
                    e0_cls = slt_pkg::C_CHARCON;
                    e0_s   = 32'(r_col);
                    e0_l   = 32'd1;
                    n_mode = slt_pkg::M_CHSKIP;
                end
                slt_pkg::M_CHSKIP: begin
                    n_mode = slt_pkg::M_IDLE;
                end
                slt_pkg::M_LT, slt_pkg::M_GT, slt_pkg::M_EQ: begin
                    e0_v   = 1'b1;
                    n_mode = slt_pkg::M_IDLE;
                    if (c == slt_pkg::CH_EQ) begin
                        e0_l   = 32'd2;
                        e0_cls = (r_mode == slt_pkg::M_LT) ? slt_pkg::C_LEQ :
                                 (r_mode == slt_pkg::M_GT) ? slt_pkg::C_GEQ : slt_pkg::C_EQL;
                    end else begin
                        e0_l      = 32'd1;
                        e0_cls    = (r_mode == slt_pkg::M_LT) ? slt_pkg::C_LSS :
                                    (r_mode == slt_pkg::M_GT) ? slt_pkg::C_GRE :
                                                                slt_pkg::C_ASSIGN;
                        use_fresh = 1'b1;
                    end
                end
                slt_pkg::M_BANG: begin
                    e0_v   = 1'b1;
                    e0_cls = slt_pkg::C_NEQ;
                    e0_l   = 32'd2;
                    n_mode = slt_pkg::M_IDLE;
                end
                default: begin
                    n_mode    = slt_pkg::M_IDLE;
                    use_fresh = 1'b1;
                end
            endcase
            n_col = col_sat;
        end

        // start a new token from the current character
        if (use_fresh) begin
            unique case (c)
                slt_pkg::CH_SPACE, slt_pkg::CH_TAB: ;
                slt_pkg::CH_DQUOTE: begin
                    n_mode  = slt_pkg::M_STR;
                    n_start = (r_col < COL_MAX) ? r_col + CW'(1) : COL_MAX;
                    n_run   = '0;
                end
                slt_pkg::CH_SQUOTE: n_mode = slt_pkg::M_CHVAL;
                slt_pkg::CH_PLUS:   begin e1_v = 1'b1; e1_cls = slt_pkg::C_PLUS;    end
                slt_pkg::CH_MINUS:  begin e1_v = 1'b1; e1_cls = slt_pkg::C_MINU;    end
                slt_pkg::CH_STAR:   begin e1_v = 1'b1; e1_cls = slt_pkg::C_MULT;    end
                slt_pkg::CH_SLASH:  begin e1_v = 1'b1; e1_cls = slt_pkg::C_DIV;     end
                slt_pkg::CH_SEMI:   begin e1_v = 1'b1; e1_cls = slt_pkg::C_SEMICN;  end
                slt_pkg::CH_COMMA:  begin e1_v = 1'b1; e1_cls = slt_pkg::C_COMMA;   end
                slt_pkg::CH_LPAREN: begin e1_v = 1'b1; e1_cls = slt_pkg::C_LPARENT; end
                slt_pkg::CH_RPAREN: begin e1_v = 1'b1; e1_cls = slt_pkg::C_RPARENT; end
                slt_pkg::CH_LBRACK: begin e1_v = 1'b1; e1_cls = slt_pkg::C_LBRACK;  end
                slt_pkg::CH_RBRACK: begin e1_v = 1'b1; e1_cls = slt_pkg::C_RBRACK;  end
                slt_pkg::CH_LBRACE: begin e1_v = 1'b1; e1_cls = slt_pkg::C_LBRACE;  end
                slt_pkg::CH_RBRACE: begin e1_v = 1'b1; e1_cls = slt_pkg::C_RBRACE;  end
                slt_pkg::CH_COLON:  begin e1_v = 1'b1; e1_cls = slt_pkg::C_COLON;   end
                slt_pkg::CH_LT:     begin n_mode = slt_pkg::M_LT;   n_start = r_col; end
                slt_pkg::CH_GT:     begin n_mode = slt_pkg::M_GT;   n_start = r_col; end
                slt_pkg::CH_EQ:     begin n_mode = slt_pkg::M_EQ;   n_start = r_col; end
                slt_pkg::CH_BANG:   begin n_mode = slt_pkg::M_BANG; n_start = r_col; end
                default: begin
                    if (c_letter || c == slt_pkg::CH_USCORE) begin
                        n_mode  = slt_pkg::M_IDENT;
                        n_start = r_col;
                        n_run   = RW'(1);
                        n_kwp   = c_letter;
                        if (c_letter) begin
                            n_let[0] = c_lower;
                        end
                    end else if (c_digit) begin
                        n_mode  = slt_pkg::M_INT;
                        n_start = r_col;
                        n_run   = RW'(1);
                    end
                end
            endcase
        end
    end

    // order the descriptors and mark the last one of this item
    always_comb begin
        t0.cls   = e0_cls;
        t0.start = slt_pkg::clamp_start(e0_s);
        t0.len   = slt_pkg::clamp_len(e0_l);
        t0.last  = !e1_v;
        t1.cls   = e1_cls;
        t1.start = slt_pkg::clamp_start(e1_s);
        t1.len   = slt_pkg::clamp_len(e1_l);
        t1.last  = 1'b1;
        o_res.tok1 = t1;
        if (e0_v) begin
            o_res.tok0 = t0;
            o_res.cnt  = e1_v ? 2'd2 : 2'd1;
        end else begin
            o_res.tok0 = t1;
            o_res.cnt  = e1_v ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= slt_pkg::M_IDLE;
            r_col   <= '0;
            r_start <= '0;
            r_run   <= '0;
            r_kwp   <= 1'b1;
        end else if (i_go) begin
            r_mode  <= n_mode;
            r_col   <= n_col;
            r_start <= n_start;
            r_run   <= n_run;
            r_kwp   <= n_kwp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_let <= n_let;
        end
    end

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_MAX && r_start <= COL_MAX)
        else $error("column beyond line limit");

    a_line_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_line_end) |=> (r_col == '0 && r_mode == slt_pkg::M_IDLE && r_run == '0))
        else $error("line end did not return lexer to column zero and idle");

endmodule

// ===== rtl/slt_outq.sv =====
// Small descriptor queue: takes up to two descriptors a cycle, hands out one per beat.
module slt_outq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_push_cnt,
    input  slt_pkg::t_tok i_tok0,
    input  slt_pkg::t_tok i_tok1,
    output logic          o_room,
    output logic          o_valid,
    input  logic          i_ready,
    output slt_pkg::t_tok o_tok
);

    localparam int DEPTH = slt_pkg::OUTQ_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int QW    = PW + 1;
    localparam logic [QW-1:0] ROOM_LIM = QW'(DEPTH - 2);

    slt_pkg::t_tok r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [QW-1:0] r_count;
    logic [PW-1:0] w_wr1;
    logic          w_pop;

    assign w_wr1   = r_wr + PW'(1);
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= ROOM_LIM);
    assign o_tok   = r_mem[r_rd];
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_tok0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[w_wr1] <= i_tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PW'(i_push_cnt);
            r_rd    <= r_rd + PW'(w_pop);
            r_count <= r_count + QW'(i_push_cnt) - QW'(w_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QW'(DEPTH))
        else $error("descriptor queue overflow");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_cnt != 2'd0) |-> o_room)
        else $error("push without room for two descriptors");

    a_last_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_cnt == 2'd2) |-> (i_tok1.last && !i_tok0.last))
        else $error("two descriptors of one item carry wrong last marks");

endmodule

// ===== rtl/source_lexer_token_descriptors_core.sv =====
// Top level of the token descriptor lexer: input register, lexer pass and descriptor queue.
//
//  channel   dir  beat carries
//  s_axis    in   tdata[7:0] char_code, tlast line_end
//  m_axis    out  tdata[5:0] token_class, [15:6] token_start, [26:16] token_length,
//                 [31:27] zero; tlast last_of_run
//
// One character beat is taken every cycle while input is not refused; the lexer pass
// turns it into zero, one or two descriptors while it sits in the input register and
// the queue has room for two; the queue then hands them out on m_axis.
// A character yielding two descriptors occupies two output beats; the queue of four
// descriptors accepts a new pass while it has room for two.
// Reset (synchronous, active low) empties the input register and queue and returns the
// lexer to idle at column zero. Output stalls hold the queue head; input is refused
// only when the input register is full and the queue lacks room for two descriptors.
module source_lexer_token_descriptors_core #(
    parameter int LINE_MAX    = slt_pkg::LINE_MAX_DEF,
    parameter int KEYWORD_MAX = slt_pkg::KEYWORD_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [5:0] token_class, [15:6] token_start,
                                        // [26:16] token_length, [31:27] zero
    output logic        m_axis_tlast
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_le;

    logic          w_room;
    logic          w_go;
    slt_pkg::t_res w_res;
    slt_pkg::t_tok w_head;
    logic [1:0]    w_push_cnt;

    // run the lexer pass on the held character once the queue can take two descriptors
    assign w_go          = r_in_valid && w_room;
    assign s_axis_tready = !r_in_valid || w_go;
    assign w_push_cnt    = w_go ? w_res.cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // hold the payload of the last accepted beat
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_char <= s_axis_tdata;
            r_le   <= s_axis_tlast;
        end
    end

    slt_lexer #(
        .LINE_MAX    (LINE_MAX),
        .KEYWORD_MAX (KEYWORD_MAX)
    ) u_lexer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (w_go),
        .i_char_code (r_char),
        .i_line_end  (r_le),
        .o_res       (w_res)
    );

    slt_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_tok0     (w_res.tok0),
        .i_tok1     (w_res.tok1),
        .o_room     (w_room),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_tok      (w_head)
    );

    // pack the queue head onto the output beat
    assign m_axis_tdata = {5'd0, w_head.len, w_head.start, w_head.cls};
    assign m_axis_tlast = w_head.last;

endmodule

// ===== tb/source_lexer_token_descriptors_core_test.sv =====
// Self-checking stream testbench for the token descriptor lexer.
`timescale 1ns / 1ps

module source_lexer_token_descriptors_core_test;
    import slt_pkg::*;

    localparam int LINE_MAX    = LINE_MAX_DEF;
    localparam int KEYWORD_MAX = KEYWORD_MAX_DEF;
    localparam int RAND_ITEMS  = 450;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 23;
    localparam int HOLD_AT     = 100;  // descriptors seen before the long output hold-off
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN       = 8;    // settle time after the last descriptor is checked

    // One expected descriptor
    typedef struct {
        t_class      cls;
        logic [9:0]  start;
        logic [10:0] len;
        logic        last;
    } token_desc_t;

    // One directed row: text repeated reps times, optionally closed by a line end.
    // A row marked known carries its descriptor (or none) instead of the prediction.
    typedef struct {
        string       txt;
        int          reps;
        bit          eol;
        bit          known;
        int          n_known;
        t_class      cls;
        int          start;
        int          len;
    } lex_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] char_code
    logic        s_axis_tlast = 1'b0;    // line_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [5:0] token_class, [15:6] token_start,
                                         // [26:16] token_length, [31:27] zero
    logic        m_axis_tlast;           // last_of_run

    source_lexer_token_descriptors_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Keyword spellings in class order, starting at the const keyword
    string kw_words [15] = '{
        "const", "int", "char", "void", "main", "if", "else", "switch",
        "case", "default", "while", "for", "scanf", "printf", "return"
    };

    // Directed stimulus: every class but C_EQL, keyword case folding, lookahead, the line-end
    // closures, and column and length saturation on one long line
    lex_row_t plan [20] = '{
        '{"+", 1, 1'b0, 1'b1, 1, C_PLUS, 0, 1},
        '{"\377", 1, 1'b0, 1'b1, 0, C_IDENFR, 0, 0},
        '{"", 1, 1'b1, 1'b1, 0, C_IDENFR, 0, 0},
        '{"iF Default;printf1 _const returns defaults", 1, 1'b1, 1'b0, 0, C_IDENFR, 0, 0},
        '{"const int char void main if else switch", 1, 1'b0, 1'b0, 0, C_IDENFR, 0, 0},
        '{" case default while for scanf printf return", 1, 1'b1, 1'b0, 0, C_IDENFR, 0, 0},
        '{"0123456789x<=<>>=>==!=!x=y!", 1, 1'b1, 1'b0, 0, C_IDENFR, 0, 0},
        '{"+-*/;,()[]{}:\t+", 1, 1'b1, 1'b0, 0, C_IDENFR, 0, 0},
        '{"<", 1, 1'b1, 1'b1, 1, C_LSS, 0, 1},
        '{">", 1, 1'b1, 1'b1, 1, C_GRE, 0, 1},
        '{"=", 1, 1'b1, 1'b1, 1, C_ASSIGN, 0, 1},
        '{"!", 1, 1'b1, 1'b1, 1, C_NEQ, 0, 1},
        '{"'", 1, 1'b1, 1'b1, 1, C_CHARCON, 1, 0},
        '{"'xy+'a", 1, 1'b1, 1'b0, 0, C_IDENFR, 0, 0},
        '{"\"ab\tc\"\"abc", 1, 1'b1, 1'b0, 0, C_IDENFR, 0, 0},
        '{"a", 1030, 1'b0, 1'b1, 0, C_IDENFR, 0, 0},
        '{" ", 1, 1'b0, 1'b1, 1, C_IDENFR, 0, 1024},
        '{"+", 1, 1'b0, 1'b1, 1, C_PLUS, 1023, 1},
        '{"\"", 1, 1'b0, 1'b1, 0, C_IDENFR, 0, 0},
        '{"y", 50, 1'b1, 1'b1, 1, C_STRCON, 1023, 50}
    };

    // Lexer state mirrored by the predictor
    t_mode       lx_mode = M_IDLE;
    int unsigned lx_col = 0;
    int unsigned lx_start = 0;
    int unsigned lx_run = 0;
    logic [7:0]  lx_word [KEYWORD_MAX];
    bit          lx_kw_ok = 1'b1;

    token_desc_t step_tokens[$];     // descriptors caused by the current character
    token_desc_t pending_tokens[$];  // descriptors still owed by the block
    logic [8:0]  line_q[$];          // {line_end, char_code} beats of the current line

    bit steady = 1'b0;               // suppress idling on both sides
    int errors = 0;
    int chars_sent = 0;
    int lines_sent = 0;
    int rand_items = 0;
    int beats_seen = 0;
    int kw_seen = 0;
    int pairs_seen = 0;
    int cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
    endfunction

    function automatic void add_tok(input t_class cls, input int unsigned st,
                                    input int unsigned ln);
        token_desc_t t;
        t.cls   = cls;
        t.start = (st > 1023) ? 10'd1023 : st[9:0];
        t.len   = (ln > 2047) ? 11'd2047 : ln[10:0];
        t.last  = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void bump_run();
        if (lx_run < LINE_MAX) lx_run++;
    endfunction

    // Keep lowercase letters while the word can still be a keyword
    function automatic void grow_ident(input logic [7:0] c);
        if (is_alpha(c) && lx_run < KEYWORD_MAX) begin
            lx_word[lx_run] = (c <= CH_UP_Z) ? c + CASE_OFFSET : c;
        end else begin
            lx_kw_ok = 1'b0;
        end
        bump_run();
    endfunction

    function automatic t_class ident_kind();
        bit hit;
        if (!lx_kw_ok || lx_run > KEYWORD_MAX) return C_IDENFR;
        for (int k = 0; k < 15; k++) begin
            if (kw_words[k].len() != int'(lx_run)) continue;
            hit = 1'b1;
            for (int i = 0; i < int'(lx_run); i++) begin
                if (kw_words[k][i] != lx_word[i]) hit = 1'b0;
            end
            if (hit) return t_class'(int'(C_KW_CONST) + k);
        end
        return C_IDENFR;
    endfunction

    // Character seen from the idle state
    function automatic void start_fresh(input logic [7:0] c);
        case (c)
            CH_SPACE, CH_TAB: ;
            CH_DQUOTE: begin
                lx_mode  = M_STR;
                lx_start = (lx_col + 1 > LINE_MAX - 1) ? LINE_MAX - 1 : lx_col + 1;
                lx_run   = 0;
            end
            CH_SQUOTE: lx_mode = M_CHVAL;
            CH_PLUS:   add_tok(C_PLUS, lx_col, 1);
            CH_MINUS:  add_tok(C_MINU, lx_col, 1);
            CH_STAR:   add_tok(C_MULT, lx_col, 1);
            CH_SLASH:  add_tok(C_DIV, lx_col, 1);
            CH_SEMI:   add_tok(C_SEMICN, lx_col, 1);
            CH_COMMA:  add_tok(C_COMMA, lx_col, 1);
            CH_LPAREN: add_tok(C_LPARENT, lx_col, 1);
            CH_RPAREN: add_tok(C_RPARENT, lx_col, 1);
            CH_LBRACK: add_tok(C_LBRACK, lx_col, 1);
            CH_RBRACK: add_tok(C_RBRACK, lx_col, 1);
            CH_LBRACE: add_tok(C_LBRACE, lx_col, 1);
            CH_RBRACE: add_tok(C_RBRACE, lx_col, 1);
            CH_COLON:  add_tok(C_COLON, lx_col, 1);
            CH_LT: begin
                lx_mode  = M_LT;
                lx_start = lx_col;
            end
            CH_GT: begin
                lx_mode  = M_GT;
                lx_start = lx_col;
            end
            CH_EQ: begin
                lx_mode  = M_EQ;
                lx_start = lx_col;
            end
            CH_BANG: begin
                lx_mode  = M_BANG;
                lx_start = lx_col;
            end
            default: begin
                if (is_alpha(c) || c == CH_USCORE) begin
                    lx_mode  = M_IDENT;
                    lx_start = lx_col;
                    lx_run   = 0;
                    lx_kw_ok = 1'b1;
                    foreach (lx_word[i]) lx_word[i] = 8'h00;
                    grow_ident(c);
                end else if (is_num(c)) begin
                    lx_mode  = M_INT;
                    lx_start = lx_col;
                    lx_run   = 1;
                end
            end
        endcase
    endfunction

    // Advance the predicted lexer by one beat; leave its descriptors in step_tokens
    function automatic void lex_predict(input logic [7:0] c, input logic eol);
        t_class pair_cls;
        t_class single_cls;
        step_tokens.delete();
        if (eol) begin
            case (lx_mode)
                M_IDENT: add_tok(ident_kind(), lx_start, lx_run);
                M_INT:   add_tok(C_INTCON, lx_start, lx_run);
                M_STR:   add_tok(C_STRCON, lx_start, lx_run);
                M_CHVAL: add_tok(C_CHARCON, lx_col, 0);
                M_LT:    add_tok(C_LSS, lx_start, 1);
                M_GT:    add_tok(C_GRE, lx_start, 1);
                M_EQ:    add_tok(C_ASSIGN, lx_start, 1);
                M_BANG:  add_tok(C_NEQ, lx_start, 1);
                default: ;
            endcase
            lx_mode = M_IDLE;
            lx_col  = 0;
            lx_run  = 0;
        end else begin
            case (lx_mode)
                M_IDENT: begin
                    if (is_alpha(c) || is_num(c) || c == CH_USCORE) begin
                        grow_ident(c);
                    end else begin
                        add_tok(ident_kind(), lx_start, lx_run);
                        lx_mode = M_IDLE;
                        start_fresh(c);
                    end
                end
                M_INT: begin
                    if (is_num(c)) begin
                        bump_run();
                    end else begin
                        add_tok(C_INTCON, lx_start, lx_run);
                        lx_mode = M_IDLE;
                        start_fresh(c);
                    end
                end
                M_STR: begin
                    if (c == CH_DQUOTE) begin
                        add_tok(C_STRCON, lx_start, lx_run);
                        lx_mode = M_IDLE;
                    end else begin
                        bump_run();
                    end
                end
                M_CHVAL: begin
                    add_tok(C_CHARCON, lx_col, 1);
                    lx_mode = M_CHSKIP;
                end
                M_CHSKIP: lx_mode = M_IDLE;
                M_LT, M_GT, M_EQ: begin
                    pair_cls   = (lx_mode == M_LT) ? C_LEQ : (lx_mode == M_GT) ? C_GEQ : C_EQL;
                    single_cls = (lx_mode == M_LT) ? C_LSS :
                                 (lx_mode == M_GT) ? C_GRE : C_ASSIGN;
                    lx_mode = M_IDLE;
                    if (c == CH_EQ) begin
                        add_tok(pair_cls, lx_start, 2);
                    end else begin
                        add_tok(single_cls, lx_start, 1);
                        start_fresh(c);
                    end
                end
                M_BANG: begin
                    add_tok(C_NEQ, lx_start, 2);
                    lx_mode = M_IDLE;
                end
                default: begin
                    lx_mode = M_IDLE;
                    start_fresh(c);
                end
            endcase
            if (lx_col < LINE_MAX - 1) lx_col++;
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    endfunction

    function automatic void owe_token(input token_desc_t t);
        pending_tokens.push_back(t);
        if (t.cls >= C_KW_CONST) kw_seen++;
    endfunction

    // Offer one character beat, idling at random first; predict once it is taken
    task automatic send_beat(input logic [7:0] ch, input logic eol, input bit predicted);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= eol;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        chars_sent++;
        if (eol) lines_sent++;
        lex_predict(ch, eol);
        if (step_tokens.size() == 2) pairs_seen++;
        if (predicted) foreach (step_tokens[i]) owe_token(step_tokens[i]);
    endtask

    task automatic send_line(input bit predicted);
        foreach (line_q[i]) send_beat(line_q[i][7:0], line_q[i][8], predicted);
    endtask

    function automatic void put_char(input logic [7:0] ch);
        line_q.push_back({1'b0, ch});
    endfunction

    function automatic void put_text(input string s, input int reps);
        repeat (reps) begin
            for (int i = 0; i < s.len(); i++) put_char(s[i]);
        end
    endfunction

    function automatic logic [7:0] any_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range(CH_LOW_A, CH_LOW_Z))
                                    : 8'($urandom_range(CH_UP_A, CH_UP_Z));
    endfunction

    function automatic logic [7:0] any_digit();
        return 8'($urandom_range(CH_DIGIT_0, CH_DIGIT_9));
    endfunction

    // Build a line of mostly well-formed tokens with random content, some noise
    function automatic void build_random_line();
        string       ops [8] = '{"<", "<=", ">", ">=", "=", "==", "!=", "!"};
        string       punct = "+-*/;,()[]{}:";
        string       word;
        logic [7:0]  ch;
        int          n;
        int          pick;
        line_q.delete();
        repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 14))
                0, 1, 2: begin
                    put_char($urandom_range(0, 7) == 0 ? CH_USCORE : any_letter());
                    repeat ($urandom_range(0, 8)) begin
                        pick = $urandom_range(0, 9);
                        put_char(pick < 7 ? any_letter() : pick < 9 ? any_digit() : CH_USCORE);
                    end
                end
                3, 4, 5: begin
                    word = kw_words[$urandom_range(0, 14)];
                    for (int i = 0; i < word.len(); i++) begin
                        ch = word[i];
                        put_char($urandom_range(0, 1) ? ch - CASE_OFFSET : ch);
                    end
                    if ($urandom_range(0, 5) == 0) put_char($urandom_range(0, 1) ?
                                                            any_letter() : any_digit());
                end
                6, 7: repeat ($urandom_range(1, 6)) put_char(any_digit());
                8: begin
                    put_char(CH_DQUOTE);
                    repeat ($urandom_range(0, 8)) begin
                        do ch = 8'($urandom_range(0, 255)); while (ch == CH_DQUOTE);
                        put_char(ch);
                    end
                    if ($urandom_range(0, 99) < 85) put_char(CH_DQUOTE);
                end
                9: begin
                    put_char(CH_SQUOTE);
                    put_char(8'($urandom_range(0, 255)));
                    put_char(8'($urandom_range(0, 255)));
                end
                10, 11: begin
                    put_text(ops[$urandom_range(0, 7)], 1);
                    if (line_q[line_q.size() - 1][7:0] == CH_BANG)
                        put_char(8'($urandom_range(0, 255)));
                end
                12, 13: put_char(punct[$urandom_range(0, punct.len() - 1)]);
                default: put_char(8'($urandom_range(0, 255)));
            endcase
            n = $urandom_range(0, 3);
            if (n == 3) put_char(CH_TAB);
            else repeat (n) put_char(CH_SPACE);
        end
        // Line end with a random, ignored character code
        line_q.push_back({1'b1, 8'($urandom_range(0, 255))});
    endfunction

    // Receive descriptors, idle at random, and once hold off for a long stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                beats_seen++;
                if (pending_tokens.size() == 0) begin
                    $error("unexpected descriptor: class %0d start %0d length %0d",
                           m_axis_tdata[5:0], m_axis_tdata[15:6], m_axis_tdata[26:16]);
                    errors++;
                end else begin
                    token_desc_t want;
                    want = pending_tokens.pop_front();
                    if (m_axis_tdata[5:0] !== want.cls) begin
                        $error("token_class: expected %0d, got %0d", want.cls,
                               m_axis_tdata[5:0]);
                        errors++;
                    end
                    if (m_axis_tdata[15:6] !== want.start) begin
                        $error("token_start: expected %0d, got %0d", want.start,
                               m_axis_tdata[15:6]);
                        errors++;
                    end
                    if (m_axis_tdata[26:16] !== want.len) begin
                        $error("token_length: expected %0d, got %0d", want.len,
                               m_axis_tdata[26:16]);
                        errors++;
                    end
                    if (m_axis_tdata[31:27] !== 5'd0) begin
                        $error("tdata padding: expected 0, got %0d", m_axis_tdata[31:27]);
                        errors++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_of_run: expected %0d, got %0d", want.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && beats_seen >= HOLD_AT) begin
                // Stall the output long enough for the block to refuse input
                hold_done     <= 1'b1;
                hold_left     <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout with %0d descriptors outstanding", pending_tokens.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        foreach (lx_word[i]) lx_word[i] = 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows
        foreach (plan[r]) begin
            line_q.delete();
            put_text(plan[r].txt, plan[r].reps);
            if (plan[r].eol) line_q.push_back({1'b1, 8'h00});
            send_line(!plan[r].known);
            // The row's only descriptor comes from its final beat, just taken
            if (plan[r].known && plan[r].n_known != 0) begin
                owe_token('{plan[r].cls, 10'(plan[r].start), 11'(plan[r].len), 1'b1});
            end
        end

        // Random lines, with a stretch free of idling in the middle
        while (rand_items < RAND_ITEMS) begin
            steady = (rand_items >= 150 && rand_items < 300);
            build_random_line();
            foreach (line_q[i]) begin
                if (line_q[i][8] || (line_q[i][7:0] != CH_SPACE && line_q[i][7:0] != CH_TAB))
                    rand_items++;
            end
            send_line(1'b1);
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("sent %0d characters on %0d lines; checked %0d descriptors",
                 chars_sent, lines_sent, beats_seen);
        $display("including %0d keywords and %0d two-descriptor characters",
                 kw_seen, pairs_seen);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== source_lexer_token_descriptors_core.f =====
rtl/slt_pkg.sv
rtl/slt_lexer.sv
rtl/slt_outq.sv
rtl/source_lexer_token_descriptors_core.sv
tb/source_lexer_token_descriptors_core_test.sv
